// ===== src/swm_pkg.sv =====
// Shared types and constants of the sliding window median core.
// No dependencies; every other file of the block refers to it by scoped names.
package swm_pkg;

   localparam int VALUE_W        = 24;
   localparam int ORDER_W        = 6;
   localparam int DEF_MAX_WINDOW = 64;
   localparam int DEF_COUNT_W    = $clog2(DEF_MAX_WINDOW + 1);

   localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd4;

   typedef logic signed [VALUE_W-1:0] value_type;

   // What one cell shows its neighbors: its sample and whether a new
   // sample would sort in front of it.
   typedef struct packed {
      logic      occ;
      logic      ok;
      logic      gt;
      value_type value;
   } link_type;

   // Boundary links: nothing to the left sorts after the new sample,
   // the empty slot past the right end always sorts after it.
   localparam link_type LINK_EDGE_LO = '{occ: 1'b0, ok: 1'b0, gt: 1'b0, value: '0};
   localparam link_type LINK_EDGE_HI = '{occ: 1'b0, ok: 1'b0, gt: 1'b1, value: '0};

endpackage

// ===== src/swm_if.sv =====
// Stream and register-write interfaces of the sliding window median core.
// Depends on swm_pkg for payload widths.
interface swm_req_if;
   logic                valid;
   logic                ready;
   swm_pkg::value_type  sample_value;
   logic                sample_valid;

   modport source (output valid, output sample_value, output sample_valid, input ready);
   modport sink   (input valid, input sample_value, input sample_valid, output ready);
endinterface

interface swm_rsp_if #(
   parameter int COUNT_W = swm_pkg::DEF_COUNT_W
);
   logic                valid;
   logic                ready;
   swm_pkg::value_type  median_value;
   logic                ready_res;
   logic [COUNT_W-1:0]  valid_count;

   modport source (output valid, output median_value, output ready_res,
                   output valid_count, input ready);
   modport sink   (input valid, input median_value, input ready_res,
                   input valid_count, output ready);
endinterface

interface swm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [swm_pkg::ORDER_W-1:0]   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/swm_cell.sv =====
// One slot of the sorted sample chain: value, valid flag and age.
// Depends on swm_pkg for the link type.
module swm_cell #(
   parameter int AGE_W = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                accept,
   input  logic                x_ok,
   input  swm_pkg::value_type  x_value,
   input  logic [AGE_W-1:0]    last_age,
   input  swm_pkg::link_type   left_link,
   input  logic [AGE_W-1:0]    left_age,
   input  logic                left_dle,
   input  swm_pkg::link_type   right_link,
   input  logic [AGE_W-1:0]    right_age,
   input  logic                own_dle,
   output swm_pkg::link_type   own_link,
   output logic [AGE_W-1:0]    own_age,
   output logic                del
);

   logic               occ_ff, occ_in;
   logic               ok_ff, ok_in;
   swm_pkg::value_type value_ff, value_in;
   logic [AGE_W-1:0]   age_ff, age_in;

   swm_pkg::link_type  cur, prv;
   logic [AGE_W-1:0]   cur_age, prv_age;
   logic               gt_own;

   always_comb begin
      if (!occ_ff) begin
         gt_own = 1'b1;
      end else if (!x_ok) begin
         gt_own = 1'b0;
      end else if (!ok_ff) begin
         gt_own = 1'b1;
      end else begin
         gt_own = (x_value < value_ff);
      end

      own_link = '{occ: occ_ff, ok: ok_ff, gt: gt_own, value: value_ff};
      own_age  = age_ff;
      del      = occ_ff && (age_ff == last_age);

      // close the gap of the evicted slot first
      cur     = own_dle  ? right_link : own_link;
      cur_age = own_dle  ? right_age  : age_ff;
      prv     = left_dle ? own_link   : left_link;
      prv_age = left_dle ? age_ff     : left_age;

      occ_in   = occ_ff;
      ok_in    = ok_ff;
      value_in = value_ff;
      age_in   = age_ff;
      if (clear) begin
         occ_in = 1'b0;
      end else if (accept) begin
         if (cur.gt && !prv.gt) begin
            occ_in   = 1'b1;
            ok_in    = x_ok;
            value_in = x_value;
            age_in   = '0;
         end else if (cur.gt) begin
            occ_in   = prv.occ;
            ok_in    = prv.ok;
            value_in = prv.value;
            age_in   = prv_age + AGE_W'(1);
         end else begin
            occ_in   = cur.occ;
            ok_in    = cur.ok;
            value_in = cur.value;
            age_in   = cur_age + AGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      ok_ff    <= ok_in;
      value_ff <= value_in;
      age_ff   <= age_in;
   end

endmodule

// ===== src/swm_select.sv =====
// Picks the two middle valid samples out of the sorted chain.
// Depends on swm_pkg for the value type.
module swm_select #(
   parameter int MAX_WINDOW = swm_pkg::DEF_MAX_WINDOW,
   parameter int COUNT_W    = $clog2(MAX_WINDOW + 1),
   parameter int IDX_W      = $clog2(MAX_WINDOW)
) (
   input  swm_pkg::value_type  values [MAX_WINDOW],
   input  logic [COUNT_W-1:0]  count,
   output swm_pkg::value_type  lo_value,
   output swm_pkg::value_type  hi_value
);

   logic [COUNT_W-1:0] lo_idx, hi_idx;

   // odd count: both pick the middle; even count: the pair around it
   always_comb begin
      lo_idx   = (count - COUNT_W'(1)) >> 1;
      hi_idx   = count >> 1;
      lo_value = values[lo_idx[IDX_W-1:0]];
      hi_value = values[hi_idx[IDX_W-1:0]];
   end

endmodule

// ===== src/sliding_window_median_core.sv =====
// Sliding window median core: a sorted chain of sample cells, one per slot.
// A result passes the chain, the middle pick stage and the output register.
// Throughput: one sample per cycle unless output stalls. The chain inserts
// and evicts in one step and empties on an order write. Reset (synchronous,
// active high) empties it, sets window order 4 and drops any pending result.
// Depends on swm_pkg, swm_if, swm_cell and swm_select.
module sliding_window_median_core #(
   parameter int MAX_WINDOW = swm_pkg::DEF_MAX_WINDOW
) (
   input  logic     clock,
   input  logic     reset,
   swm_req_if.sink  req_bus,
   swm_rsp_if.source rsp_bus,
   swm_csr_if.sink  csr_bus
);

   localparam int AGE_W   = $clog2(MAX_WINDOW);
   localparam int IDX_W   = $clog2(MAX_WINDOW);
   localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W   = (AGE_W > swm_pkg::ORDER_W) ? AGE_W : swm_pkg::ORDER_W;

   // ---------------------------------------------------------------------
   // Window order register; a write empties the window
   // ---------------------------------------------------------------------
   logic [swm_pkg::ORDER_W-1:0] order_ff, order_in;
   logic                        csr_xfer;
   logic [AGE_W-1:0]            last_age;

   assign csr_bus.ready = 1'b1;
   assign csr_xfer      = csr_bus.valid && csr_bus.ready;

   always_comb begin
      order_in = csr_xfer ? csr_bus.data : order_ff;
      // oldest age a window slot reaches; length saturates at the storage
      if (CMP_W'(order_ff) >= CMP_W'(MAX_WINDOW - 1)) begin
         last_age = AGE_W'(MAX_WINDOW - 1);
      end else begin
         last_age = AGE_W'(order_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: chain update, middle pick, output register
   // ---------------------------------------------------------------------
   logic pend_ff, pend_in;
   logic pick_vld_ff, pick_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic out_free, pick_free, pick_load, req_xfer;

   always_comb begin
      out_free  = !rsp_vld_ff || rsp_bus.ready;
      pick_free = !pick_vld_ff || out_free;
      pick_load = pend_ff && pick_free;
      req_bus.ready = !pend_ff || pick_free;
      req_xfer  = req_bus.valid && req_bus.ready;

      pend_in     = req_xfer || (pend_ff && !pick_free);
      pick_vld_in = pick_load || (pick_vld_ff && !out_free);
      rsp_vld_in  = (pick_vld_ff && out_free) || (rsp_vld_ff && !rsp_bus.ready);
   end

   // ---------------------------------------------------------------------
   // Sorted cell chain: valid samples ascending, then missing ones, then
   // empty slots. Evict the slot whose age hits the window end, then
   // insert the new sample at its sorted place.
   // ---------------------------------------------------------------------
   swm_pkg::link_type   links [MAX_WINDOW];
   logic [AGE_W-1:0]    ages  [MAX_WINDOW];
   swm_pkg::value_type  values [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] del_vec, ok_vec, dle_vec;
   logic                del_ok;

   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      swm_pkg::link_type left_link, right_link;
      logic [AGE_W-1:0]  left_age, right_age;
      logic              left_dle;

      // eviction at or left of this slot
      assign dle_vec[k] = |del_vec[k:0];
      assign ok_vec[k]  = links[k].ok;
      assign values[k]  = links[k].value;

      if (k == 0) begin : g_lo
         assign left_link = swm_pkg::LINK_EDGE_LO;
         assign left_age  = '0;
         assign left_dle  = 1'b0;
      end else begin : g_mid_lo
         assign left_link = links[k-1];
         assign left_age  = ages[k-1];
         assign left_dle  = dle_vec[k-1];
      end

      if (k == MAX_WINDOW - 1) begin : g_hi
         assign right_link = swm_pkg::LINK_EDGE_HI;
         assign right_age  = '0;
      end else begin : g_mid_hi
         assign right_link = links[k+1];
         assign right_age  = ages[k+1];
      end

      swm_cell #(
         .AGE_W (AGE_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear      (csr_xfer),
         .accept     (req_xfer),
         .x_ok       (req_bus.sample_valid),
         .x_value    (req_bus.sample_value),
         .last_age   (last_age),
         .left_link  (left_link),
         .left_age   (left_age),
         .left_dle   (left_dle),
         .right_link (right_link),
         .right_age  (right_age),
         .own_dle    (dle_vec[k]),
         .own_link   (links[k]),
         .own_age    (ages[k]),
         .del        (del_vec[k])
      );
   end

   assign del_ok = |(del_vec & ok_vec);

   // ---------------------------------------------------------------------
   // Valid sample count, tracks the chain
   // ---------------------------------------------------------------------
   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (csr_xfer) begin
         cnt_in = '0;
      end else if (req_xfer) begin
         cnt_in = cnt_ff + COUNT_W'(req_bus.sample_valid) - COUNT_W'(del_ok);
      end
   end

   // ---------------------------------------------------------------------
   // Middle pick stage: sample the chain once it holds the pending item
   // ---------------------------------------------------------------------
   swm_pkg::value_type lo_value, hi_value;
   swm_pkg::value_type pick_lo_ff, pick_hi_ff;
   logic [COUNT_W-1:0] pick_cnt_ff;

   swm_select #(
      .MAX_WINDOW (MAX_WINDOW),
      .COUNT_W    (COUNT_W),
      .IDX_W      (IDX_W)
   ) u_select (
      .values   (values),
      .count    (cnt_ff),
      .lo_value (lo_value),
      .hi_value (hi_value)
   );

   // ---------------------------------------------------------------------
   // Output stage: average the middle pair with floor, zero when empty
   // ---------------------------------------------------------------------
   logic signed [swm_pkg::VALUE_W:0] pair_sum;
   swm_pkg::value_type               med_in, med_ff;
   logic                             rdy_in, rdy_ff;
   logic [COUNT_W-1:0]               vcnt_ff;

   always_comb begin
      pair_sum = {pick_lo_ff[swm_pkg::VALUE_W-1], pick_lo_ff}
               + {pick_hi_ff[swm_pkg::VALUE_W-1], pick_hi_ff};
      rdy_in   = (pick_cnt_ff != '0);
      med_in   = rdy_in ? pair_sum[swm_pkg::VALUE_W:1] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff    <= swm_pkg::ORDER_RESET;
         cnt_ff      <= '0;
         pend_ff     <= 1'b0;
         pick_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         order_ff    <= order_in;
         cnt_ff      <= cnt_in;
         pend_ff     <= pend_in;
         pick_vld_ff <= pick_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      // payload: load only when the stage advances
      if (pick_load) begin
         pick_lo_ff  <= lo_value;
         pick_hi_ff  <= hi_value;
         pick_cnt_ff <= cnt_ff;
      end
      if (pick_vld_ff && out_free) begin
         med_ff  <= med_in;
         rdy_ff  <= rdy_in;
         vcnt_ff <= pick_cnt_ff;
      end
   end

   assign rsp_bus.valid        = rsp_vld_ff;
   assign rsp_bus.median_value = med_ff;
   assign rsp_bus.ready_res    = rdy_ff;
   assign rsp_bus.valid_count  = vcnt_ff;

endmodule

// ===== src/swm_checker.sv =====
// Port-level checks of the sliding window median core, with its bind.
// Depends on swm_pkg and on the top level's ports.
module swm_checker #(
   parameter int MAX_WINDOW = swm_pkg::DEF_MAX_WINDOW,
   parameter int COUNT_W    = $clog2(MAX_WINDOW + 1)
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input swm_pkg::value_type median_value,
   input logic               ready_res,
   input logic [COUNT_W-1:0] valid_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(median_value)
         && $stable(ready_res) && $stable(valid_count))
      else $error("result changed while stalled");

   a_ready_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ready_res == (valid_count != '0)))
      else $error("ready_res disagrees with valid_count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !ready_res |-> median_value == '0)
      else $error("empty window gave a nonzero median");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> valid_count <= COUNT_W'(MAX_WINDOW))
      else $error("valid_count beyond storage");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sliding_window_median_core swm_checker #(
   .MAX_WINDOW (MAX_WINDOW)
) u_swm_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .median_value (rsp_bus.median_value),
   .ready_res    (rsp_bus.ready_res),
   .valid_count  (rsp_bus.valid_count)
);
